/* rtl/assert_macros.svh */
// assertion helpers used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the rising clock edge, off during reset
`define SBM_ASSERT_IMPLIES(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed: implication");

// next-cycle implication on the rising clock edge, off during reset
`define SBM_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/sbm_pkg.sv */
package sbm_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned MAP_W       = 18;
   localparam int unsigned PRG_MASK_W  = 18;
   localparam int unsigned CHR_MASK_W  = 17;
   localparam int unsigned PRG_BANK_W  = 4;
   localparam int unsigned LOAD_W      = 5;
   localparam int unsigned COUNT_W     = 3;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 18;

   localparam logic [PRG_MASK_W-1:0] PRG_MASK_RESET  = 18'h3ffff;
   localparam logic [CHR_MASK_W-1:0] CHR_MASK_RESET  = 17'h1ffff;
   localparam logic [PRG_BANK_W-1:0] LAST_BANK_RESET = 4'hf;

   // loader holds a marker bit at the top when emptied by a reset byte or a commit
   localparam logic [LOAD_W-1:0]  SHIFT_EMPTY   = 5'h10;
   localparam logic [LOAD_W-1:0]  PRG_MODE_BITS = 5'h0c;
   localparam logic [COUNT_W-1:0] LOAD_LAST     = 3'd4;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      SPACE_PRG = 2'd0,
      SPACE_CHR = 2'd1,
      SPACE_RAM = 2'd2,
      SPACE_NT  = 2'd3
   } space_type;

   typedef enum logic [1:0] {
      MIRROR_FOUR = 2'd0,
      MIRROR_ONE  = 2'd1,
      MIRROR_VERT = 2'd2,
      MIRROR_HORZ = 2'd3
   } mirror_type;

   // control bits 3..2
   typedef enum logic [1:0] {
      PRG_MODE_32K_A    = 2'd0,
      PRG_MODE_32K_B    = 2'd1,
      PRG_MODE_FIX_LOW  = 2'd2,
      PRG_MODE_FIX_HIGH = 2'd3
   } prg_mode_type;

   // control bits 1..0 as loaded
   typedef enum logic [1:0] {
      NT_SEL_ONE_LOW  = 2'd0,
      NT_SEL_ONE_HIGH = 2'd1,
      NT_SEL_VERT     = 2'd2,
      NT_SEL_HORZ     = 2'd3
   } nt_sel_type;

   // target of a completed serial load, address bits 14..13
   typedef enum logic [1:0] {
      LOAD_CONTROL  = 2'd0,
      LOAD_CHR_LOW  = 2'd1,
      LOAD_CHR_HIGH = 2'd2,
      LOAD_PRG      = 2'd3
   } load_target_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRG_SIZE_MASK = 2'd0,
      CSR_CHR_SIZE_MASK = 2'd1,
      CSR_LAST_PRG_BANK = 2'd2
   } csr_index_type;

   // mapper state seen by the translation logic
   typedef struct packed {
      logic [LOAD_W-1:0]     control;
      logic [LOAD_W-1:0]     chr_bank_low;
      logic [LOAD_W-1:0]     chr_bank_high;
      logic [PRG_BANK_W-1:0] prg_bank;
      logic                  ram_enabled;
      logic [1:0]            mirror;
      logic                  upper_screen;
      logic [PRG_MASK_W-1:0] prg_size_mask;
      logic [CHR_MASK_W-1:0] chr_size_mask;
      logic [PRG_BANK_W-1:0] last_prg_bank;
   } sbm_state_type;

   typedef struct packed {
      logic [MAP_W-1:0] mapped_addr;
      logic             mem_enable;
      logic             mem_write;
      logic [1:0]       mirror_mode;
   } sbm_result_type;

endpackage

/* rtl/sbm_if.sv */
interface sbm_req_if import sbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [1:0]        space;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] value;

   modport source (output valid, op, space, addr, value, input ready);
   modport sink (input valid, op, space, addr, value, output ready);
endinterface

interface sbm_rsp_if import sbm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAP_W-1:0] mapped_addr;
   logic             mem_enable;
   logic             mem_write;
   logic [1:0]       mirror_mode;

   modport source (output valid, mapped_addr, mem_enable, mem_write, mirror_mode,
                   input ready);
   modport sink (input valid, mapped_addr, mem_enable, mem_write, mirror_mode,
                 output ready);
endinterface

interface sbm_csr_if import sbm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sbm_translate.sv */
module sbm_translate import sbm_pkg::*; (
   input  sbm_state_type     state,
   input  logic              op,
   input  logic [1:0]        space,
   input  logic [ADDR_W-1:0] addr,
   output sbm_result_type    result
);

   logic [MAP_W-1:0]      prg_addr;
   logic [CHR_MASK_W-1:0] chr_addr;
   logic [ADDR_W-1:0]     nt_addr;

   // program windows
   always_comb begin
      case (prg_mode_type'(state.control[3:2]))
         PRG_MODE_FIX_LOW: begin
            prg_addr = addr[14] ? {state.prg_bank, addr[13:0]}
                                : {{PRG_BANK_W{1'b0}}, addr[13:0]};
         end
         PRG_MODE_FIX_HIGH: begin
            prg_addr = addr[14] ? {state.last_prg_bank, addr[13:0]}
                                : {state.prg_bank, addr[13:0]};
         end
         default: begin
            // 32k window, low bank bit ignored
            prg_addr = {state.prg_bank[PRG_BANK_W-1:1], addr[14:0]};
         end
      endcase
   end

   // character windows
   always_comb begin
      if (state.control[4]) begin
         chr_addr = addr[12] ? {state.chr_bank_high, addr[11:0]}
                             : {state.chr_bank_low, addr[11:0]};
      end else begin
         chr_addr = {state.chr_bank_low[LOAD_W-1:1], addr[12:0]};
      end
   end

   // nametable mirroring
   always_comb begin
      case (mirror_type'(state.mirror))
         MIRROR_ONE:  nt_addr = (addr & 16'h33ff) | (state.upper_screen ? 16'h0800 : 16'h0000);
         MIRROR_VERT: nt_addr = addr & 16'h37ff;
         MIRROR_HORZ: nt_addr = (addr & 16'h33ff) | {5'd0, addr[11], 10'd0};
         default:     nt_addr = addr;
      endcase
   end

   always_comb begin
      result             = '0;
      result.mem_enable  = 1'b1;
      result.mem_write   = 1'b0;
      result.mirror_mode = state.mirror;
      case (space_type'(space))
         SPACE_PRG: result.mapped_addr = prg_addr & state.prg_size_mask;
         SPACE_CHR: result.mapped_addr = {1'b0, chr_addr & state.chr_size_mask};
         SPACE_RAM: begin
            result.mapped_addr = {5'd0, addr[12:0]};
            result.mem_enable  = state.ram_enabled;
            result.mem_write   = (op == OP_WRITE) && state.ram_enabled;
         end
         default: result.mapped_addr = {2'd0, nt_addr};
      endcase
   end

endmodule

/* rtl/serial_loaded_bank_mapper_top.sv */
// Serial-loaded cartridge bank mapper. Each request beat is one bus access (space, address,
// read or write, data byte) and yields exactly one response beat with the translated address,
// the memory enable, the work RAM write strobe and the nametable mirroring mode, all taken
// from the mapper state as it stood before that access. Program-space writes feed a five-bit
// serial loader, lsb first; a byte with bit 7 set clears the loader and forces the fixed-last
// 16k program mode, and every fifth bit commits to control, a character bank or the program
// bank selected by address bits 14..13. Throughput is one access per clock while responses are
// drained, through the single response register; a request is taken whenever that register is
// empty or being drained. The size masks and last program bank are written through the csr
// channel, which is always ready and should only be used while no access is in flight.
`include "assert_macros.svh"

module serial_loaded_bank_mapper_top import sbm_pkg::*; (
   input logic       clock,
   input logic       reset,
   sbm_req_if.sink   req_ch,
   sbm_rsp_if.source rsp_ch,
   sbm_csr_if.sink   csr_ch
);

   // configuration registers
   logic [PRG_MASK_W-1:0] prg_size_mask_ff;
   logic [CHR_MASK_W-1:0] chr_size_mask_ff;
   logic [PRG_BANK_W-1:0] last_prg_bank_ff;

   // mapper state and next values
   logic [LOAD_W-1:0]     shift_bits_ff, shift_bits_in;
   logic [COUNT_W-1:0]    bit_count_ff, bit_count_in;
   logic [LOAD_W-1:0]     control_reg_ff, control_reg_in;
   logic [LOAD_W-1:0]     chr_bank_low_ff, chr_bank_low_in;
   logic [LOAD_W-1:0]     chr_bank_high_ff, chr_bank_high_in;
   logic [PRG_BANK_W-1:0] prg_bank_ff, prg_bank_in;
   logic                  ram_enabled_ff, ram_enabled_in;
   logic [1:0]            mirror_state_ff, mirror_state_in;
   logic                  upper_screen_ff, upper_screen_in;

   // response stage
   logic                  rsp_valid_ff;
   sbm_result_type        rsp_data_ff;

   logic                  req_accept;
   logic                  csr_accept;
   logic                  serial_write;
   logic [LOAD_W-1:0]     shifted;
   sbm_state_type         cur_state;
   sbm_result_type        result;

   // a beat enters when the response register is free or is handed off this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_accept   = csr_ch.valid;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.mapped_addr = rsp_data_ff.mapped_addr;
   assign rsp_ch.mem_enable  = rsp_data_ff.mem_enable;
   assign rsp_ch.mem_write   = rsp_data_ff.mem_write;
   assign rsp_ch.mirror_mode = rsp_data_ff.mirror_mode;

   // translation always sees the state before this beat's own update
   always_comb begin
      cur_state.control       = control_reg_ff;
      cur_state.chr_bank_low  = chr_bank_low_ff;
      cur_state.chr_bank_high = chr_bank_high_ff;
      cur_state.prg_bank      = prg_bank_ff;
      cur_state.ram_enabled   = ram_enabled_ff;
      cur_state.mirror        = mirror_state_ff;
      cur_state.upper_screen  = upper_screen_ff;
      cur_state.prg_size_mask = prg_size_mask_ff;
      cur_state.chr_size_mask = chr_size_mask_ff;
      cur_state.last_prg_bank = last_prg_bank_ff;
   end

   sbm_translate u_translate (
      .state  (cur_state),
      .op     (req_ch.op),
      .space  (req_ch.space),
      .addr   (req_ch.addr),
      .result (result)
   );

   // any program-space write drives the serial loader, whatever the address
   assign serial_write = req_accept && (req_ch.op == OP_WRITE) &&
                         (req_ch.space == SPACE_PRG);
   // new bit enters at the top, lsb-first loading
   assign shifted      = {req_ch.value[0], shift_bits_ff[LOAD_W-1:1]};

   always_comb begin
      shift_bits_in    = shift_bits_ff;
      bit_count_in     = bit_count_ff;
      control_reg_in   = control_reg_ff;
      chr_bank_low_in  = chr_bank_low_ff;
      chr_bank_high_in = chr_bank_high_ff;
      prg_bank_in      = prg_bank_ff;
      ram_enabled_in   = ram_enabled_ff;
      mirror_state_in  = mirror_state_ff;
      upper_screen_in  = upper_screen_ff;
      if (serial_write) begin
         if (req_ch.value[7]) begin
            // loader reset: empty loader, fixed-last program mode, mirroring kept
            shift_bits_in  = SHIFT_EMPTY;
            bit_count_in   = '0;
            control_reg_in = control_reg_ff | PRG_MODE_BITS;
         end else if (bit_count_ff == LOAD_LAST) begin
            // fifth bit: commit the loaded value
            shift_bits_in = SHIFT_EMPTY;
            bit_count_in  = '0;
            case (load_target_type'(req_ch.addr[14:13]))
               LOAD_CONTROL: begin
                  control_reg_in = shifted;
                  case (nt_sel_type'(shifted[1:0]))
                     NT_SEL_ONE_LOW: begin
                        mirror_state_in = MIRROR_ONE;
                        upper_screen_in = 1'b0;
                     end
                     NT_SEL_ONE_HIGH: begin
                        mirror_state_in = MIRROR_ONE;
                        upper_screen_in = 1'b1;
                     end
                     NT_SEL_VERT: begin
                        mirror_state_in = MIRROR_VERT;
                        upper_screen_in = 1'b0;
                     end
                     default: begin
                        mirror_state_in = MIRROR_HORZ;
                        upper_screen_in = 1'b0;
                     end
                  endcase
               end
               LOAD_CHR_LOW:  chr_bank_low_in  = shifted;
               LOAD_CHR_HIGH: chr_bank_high_in = shifted;
               default: begin
                  // top bit of the program load disables work ram
                  prg_bank_in    = shifted[PRG_BANK_W-1:0];
                  ram_enabled_in = !shifted[LOAD_W-1];
               end
            endcase
         end else begin
            shift_bits_in = shifted;
            bit_count_in  = bit_count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_bits_ff    <= '0;
         bit_count_ff     <= '0;
         control_reg_ff   <= '0;
         chr_bank_low_ff  <= '0;
         chr_bank_high_ff <= '0;
         prg_bank_ff      <= '0;
         ram_enabled_ff   <= 1'b0;
         mirror_state_ff  <= MIRROR_FOUR;
         upper_screen_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         shift_bits_ff    <= shift_bits_in;
         bit_count_ff     <= bit_count_in;
         control_reg_ff   <= control_reg_in;
         chr_bank_low_ff  <= chr_bank_low_in;
         chr_bank_high_ff <= chr_bank_high_in;
         prg_bank_ff      <= prg_bank_in;
         ram_enabled_ff   <= ram_enabled_in;
         mirror_state_ff  <= mirror_state_in;
         upper_screen_ff  <= upper_screen_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   // configuration registers; index 3 is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_size_mask_ff <= PRG_MASK_RESET;
         chr_size_mask_ff <= CHR_MASK_RESET;
         last_prg_bank_ff <= LAST_BANK_RESET;
      end else if (csr_accept) begin
         case (csr_index_type'(csr_ch.index))
            CSR_PRG_SIZE_MASK: prg_size_mask_ff <= csr_ch.data[PRG_MASK_W-1:0];
            CSR_CHR_SIZE_MASK: chr_size_mask_ff <= csr_ch.data[CHR_MASK_W-1:0];
            CSR_LAST_PRG_BANK: last_prg_bank_ff <= csr_ch.data[PRG_BANK_W-1:0];
            default: ;
         endcase
      end
   end

   // loader never holds more than four pending bits
   `SBM_ASSERT_IMPLIES(a_count_range, 1'b1, bit_count_ff <= LOAD_LAST)
   // a work ram write strobe is only given with the memory enabled
   `SBM_ASSERT_IMPLIES(a_write_needs_enable, rsp_valid_ff && rsp_data_ff.mem_write,
      rsp_data_ff.mem_enable)
   // a reset byte empties the loader and forces the fixed-last program mode
   `SBM_ASSERT_NEXT(a_reset_byte, serial_write && req_ch.value[7],
      bit_count_ff == '0 && shift_bits_ff == SHIFT_EMPTY && control_reg_ff[3:2] == 2'b11)

endmodule
